FILE: rtl/core/sir_pkg.sv
// Shared constants, types and codes of the square image rotator.
package sir_pkg;

   localparam int MAX_SIDE     = 64;
   localparam int MAX_CHANNELS = 4;
   localparam int WORD_BITS    = 32;

   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE * MAX_CHANNELS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int POS_BITS    = $clog2(MAX_SIDE);
   localparam int CHAN_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   localparam int MODE_BITS  = 2;
   localparam int SIDE_BITS  = 7;
   localparam int COUNT_BITS = 3;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [ADDR_BITS-1:0]     addr_type;
   typedef logic [POS_BITS-1:0]      pos_type;
   typedef logic [CHAN_BITS-1:0]     chan_type;
   typedef logic [WORD_BITS-1:0]     word_type;
   typedef logic [SIDE_BITS-1:0]     side_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_NONE = 2'd0,
      MODE_CCW  = 2'd1,
      MODE_180  = 2'd2,
      MODE_CW   = 2'd3
   } mode_type;

   localparam csr_index_type REG_ROTATION_MODE = 2'd0;
   localparam csr_index_type REG_SIDE_LENGTH   = 2'd1;
   localparam csr_index_type REG_CHANNEL_COUNT = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

endpackage

FILE: rtl/core/sir_channels_if.sv
// Request and response stream interfaces of the square image rotator.
interface sir_req_if;
   import sir_pkg::*;
   logic     valid;
   logic     ready;
   logic     op;
   word_type pixel_in;
   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface sir_rsp_if;
   import sir_pkg::*;
   logic     valid;
   logic     ready;
   word_type pixel_out;
   logic     frame_last;
   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: rtl/core/square_image_rotator_top.sv
// Top level of the square image rotator: frame memory, address walkers, output stage.
//
//   channel   dir  handshake          payload
//   req_ch    in   valid/ready        op, pixel_in
//   rsp_ch    out  valid/ready        pixel_out, frame_last
//   csr       in   csr_we             csr_index, csr_wdata
//
// One item per cycle while req_ch.ready is high: a load writes the frame memory when it
// is accepted; a drain reads it into the read stage when accepted, the word then moves
// to the output stage and is offered on rsp_ch from there.
// The single-port-per-direction frame memory sets the rate of one item per cycle.
// Reset is synchronous; it clears the configuration registers, both walkers and the stage valid flags, not the memory.
// A stalled rsp_ch fills the output and read stages, then req_ch.ready drops.
module square_image_rotator_top (
   input  logic                   clock,
   input  logic                   reset,
   sir_req_if.sink                req_ch,
   sir_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  sir_pkg::csr_index_type csr_index,
   input  sir_pkg::csr_data_type  csr_wdata
);
   import sir_pkg::*;

   word_type  frame_mem [STORE_DEPTH];

   mode_type  mode_ff;
   side_type  side_ff;
   count_type chans_ff;

   addr_type  laddr_ff, laddr_in;
   pos_type   lcol_ff, lcol_in;
   pos_type   lrow_ff, lrow_in;
   chan_type  lch_ff, lch_in;

   logic      restart_ff, restart_in;
   addr_type  dbase_ff, dbase_in;
   addr_type  drs_ff, drs_in;
   addr_type  daddr_ff, daddr_in;
   pos_type   dcol_ff, dcol_in;
   pos_type   drow_ff, drow_in;
   chan_type  dch_ff, dch_in;

   word_type  rd_data_ff;
   logic      rd_last_ff;
   logic      rd_valid_ff, rd_valid_in;
   word_type  out_data_ff;
   logic      out_last_ff;
   logic      out_valid_ff, out_valid_in;

   side_type  s_use;
   count_type ch_use;
   pos_type   s_last;
   chan_type  ch_last;
   addr_type  s_ext;
   addr_type  plane;
   addr_type  start_off;
   addr_type  col_step;
   addr_type  row_step;
   addr_type  eff_base;
   addr_type  eff_rs;
   addr_type  eff_addr;
   addr_type  next_base;
   logic      cfg_hit;
   logic      accept;
   logic      load_acc;
   logic      drain_acc;
   logic      move_out;
   logic      load_last;
   logic      drain_last;

   always_comb begin
      priority if (side_ff == '0) begin
         s_use = side_type'(1);
      end else if (side_ff > side_type'(MAX_SIDE)) begin
         s_use = side_type'(MAX_SIDE);
      end else begin
         s_use = side_ff;
      end
      priority if (chans_ff == '0) begin
         ch_use = count_type'(1);
      end else if (chans_ff > count_type'(MAX_CHANNELS)) begin
         ch_use = count_type'(MAX_CHANNELS);
      end else begin
         ch_use = chans_ff;
      end
   end

   assign s_last  = pos_type'(s_use - side_type'(1));
   assign ch_last = chan_type'(ch_use - count_type'(1));
   assign s_ext   = addr_type'(s_use);
   assign plane   = addr_type'(s_ext * s_ext);

   always_comb begin
      unique case (mode_ff)
         MODE_NONE: begin
            start_off = '0;
            col_step  = addr_type'(1);
            row_step  = s_ext;
         end
         MODE_CCW: begin
            start_off = addr_type'(s_last);
            col_step  = s_ext;
            row_step  = '1;
         end
         MODE_180: begin
            start_off = plane - addr_type'(1);
            col_step  = '1;
            row_step  = addr_type'(0) - s_ext;
         end
         MODE_CW: begin
            start_off = plane - s_ext;
            col_step  = addr_type'(0) - s_ext;
            row_step  = addr_type'(1);
         end
         default: begin
            start_off = '0;
            col_step  = addr_type'(1);
            row_step  = s_ext;
         end
      endcase
   end

   assign cfg_hit = csr_we && (csr_index == REG_ROTATION_MODE ||
                               csr_index == REG_SIDE_LENGTH ||
                               csr_index == REG_CHANNEL_COUNT);

   assign move_out     = rd_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !rd_valid_ff || move_out;
   assign accept       = req_ch.valid && req_ch.ready;
   assign load_acc     = accept && (req_ch.op == OP_LOAD);
   assign drain_acc    = accept && (req_ch.op == OP_DRAIN);

   assign load_last  = (lcol_ff == s_last) && (lrow_ff == s_last) && (lch_ff == ch_last);
   assign drain_last = (dcol_ff == s_last) && (drow_ff == s_last) && (dch_ff == ch_last);

   assign eff_base  = restart_ff ? '0 : dbase_ff;
   assign eff_rs    = restart_ff ? start_off : drs_ff;
   assign eff_addr  = restart_ff ? start_off : daddr_ff;
   assign next_base = eff_base + plane;

   always_comb begin
      laddr_in = laddr_ff;
      lcol_in  = lcol_ff;
      lrow_in  = lrow_ff;
      lch_in   = lch_ff;
      if (load_acc) begin
         if (load_last) begin
            laddr_in = '0;
            lcol_in  = '0;
            lrow_in  = '0;
            lch_in   = '0;
         end else begin
            laddr_in = laddr_ff + addr_type'(1);
            if (lcol_ff != s_last) begin
               lcol_in = lcol_ff + pos_type'(1);
            end else begin
               lcol_in = '0;
               if (lrow_ff != s_last) begin
                  lrow_in = lrow_ff + pos_type'(1);
               end else begin
                  lrow_in = '0;
                  lch_in  = lch_ff + chan_type'(1);
               end
            end
         end
      end
   end

   always_comb begin
      restart_in = restart_ff;
      dbase_in   = dbase_ff;
      drs_in     = drs_ff;
      daddr_in   = daddr_ff;
      dcol_in    = dcol_ff;
      drow_in    = drow_ff;
      dch_in     = dch_ff;
      if (drain_acc) begin
         restart_in = 1'b0;
         dbase_in   = eff_base;
         drs_in     = eff_rs;
         if (drain_last) begin
            restart_in = 1'b1;
            dcol_in    = '0;
            drow_in    = '0;
            dch_in     = '0;
         end else if (dcol_ff != s_last) begin
            dcol_in  = dcol_ff + pos_type'(1);
            daddr_in = eff_addr + col_step;
         end else if (drow_ff != s_last) begin
            dcol_in  = '0;
            drow_in  = drow_ff + pos_type'(1);
            drs_in   = eff_rs + row_step;
            daddr_in = eff_rs + row_step;
         end else begin
            dcol_in  = '0;
            drow_in  = '0;
            dch_in   = dch_ff + chan_type'(1);
            dbase_in = next_base;
            drs_in   = next_base + start_off;
            daddr_in = next_base + start_off;
         end
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (move_out) begin
         rd_valid_in = 1'b0;
      end
      if (drain_acc) begin
         rd_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (move_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         side_ff      <= side_type'(MAX_SIDE);
         chans_ff     <= count_type'(1);
         laddr_ff     <= '0;
         lcol_ff      <= '0;
         lrow_ff      <= '0;
         lch_ff       <= '0;
         restart_ff   <= 1'b1;
         dbase_ff     <= '0;
         drs_ff       <= '0;
         daddr_ff     <= '0;
         dcol_ff      <= '0;
         drow_ff      <= '0;
         dch_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
         if (cfg_hit) begin
            unique case (csr_index)
               REG_ROTATION_MODE: mode_ff  <= mode_type'(csr_wdata[MODE_BITS-1:0]);
               REG_SIDE_LENGTH:   side_ff  <= csr_wdata[SIDE_BITS-1:0];
               REG_CHANNEL_COUNT: chans_ff <= csr_wdata[COUNT_BITS-1:0];
               default:           mode_ff  <= mode_ff;
            endcase
            laddr_ff   <= '0;
            lcol_ff    <= '0;
            lrow_ff    <= '0;
            lch_ff     <= '0;
            restart_ff <= 1'b1;
            dbase_ff   <= '0;
            drs_ff     <= '0;
            daddr_ff   <= '0;
            dcol_ff    <= '0;
            drow_ff    <= '0;
            dch_ff     <= '0;
         end else begin
            laddr_ff   <= laddr_in;
            lcol_ff    <= lcol_in;
            lrow_ff    <= lrow_in;
            lch_ff     <= lch_in;
            restart_ff <= restart_in;
            dbase_ff   <= dbase_in;
            drs_ff     <= drs_in;
            daddr_ff   <= daddr_in;
            dcol_ff    <= dcol_in;
            drow_ff    <= drow_in;
            dch_ff     <= dch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc) begin
         frame_mem[laddr_ff] <= req_ch.pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_acc) begin
         rd_data_ff <= frame_mem[eff_addr];
         rd_last_ff <= drain_last;
      end
   end

   always_ff @(posedge clock) begin
      if (move_out) begin
         out_data_ff <= rd_data_ff;
         out_last_ff <= rd_last_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pixel_out  = out_data_ff;
   assign rsp_ch.frame_last = out_last_ff;

   a_drain_fills_read_stage: assert property (@(posedge clock) disable iff (reset)
      drain_acc |=> rd_valid_ff)
      else $error("drain beat did not reach the read stage");

   a_read_stage_not_lost: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && !move_out |=> rd_valid_ff && $stable(rd_data_ff))
      else $error("read stage word dropped while output stalled");

   a_drain_walker_bounds: assert property (@(posedge clock) disable iff (reset)
      dcol_ff <= s_last && drow_ff <= s_last && dch_ff <= ch_last)
      else $error("drain walker outside the frame");

   a_load_walker_bounds: assert property (@(posedge clock) disable iff (reset)
      lcol_ff <= s_last && lrow_ff <= s_last && lch_ff <= ch_last)
      else $error("load walker outside the frame");

endmodule

FILE: bench/tb_rotation_checker.sv
// Checker of the square image rotator: follows every beat, predicts drained words and compares.
module tb_rotation_checker (
   input  logic                   clock,
   input  logic                   reset,
   sir_req_if                     req_mon,
   sir_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  sir_pkg::csr_index_type csr_index,
   input  sir_pkg::csr_data_type  csr_wdata,
   output int                     mismatch_count,
   output int                     words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sir_pkg::*;

   typedef struct packed {
      word_type pixel;
      logic     last;
   } expected_word_type;

   expected_word_type expected_words[$];
   word_type          shadow_store[STORE_DEPTH];
   mode_type          mode_q;
   side_type          side_q;
   count_type         count_q;
   int unsigned       load_pos;
   int unsigned       drain_pos;

   function automatic int unsigned side_used();
      if (side_q == 0) return 1;
      if (side_q > MAX_SIDE) return MAX_SIDE;
      return side_q;
   endfunction

   function automatic int unsigned channels_used();
      if (count_q == 0) return 1;
      if (count_q > MAX_CHANNELS) return MAX_CHANNELS;
      return count_q;
   endfunction

   function automatic int unsigned rotated_source_addr(int unsigned pos, int unsigned s);
      int unsigned plane;
      int unsigned ch;
      int unsigned rem;
      int unsigned r;
      int unsigned c;
      int unsigned sr;
      int unsigned sc;
      plane = s * s;
      ch    = pos / plane;
      rem   = pos % plane;
      r     = rem / s;
      c     = rem % s;
      case (mode_q)
         MODE_CCW: begin
            sr = c;
            sc = s - 1 - r;
         end
         MODE_180: begin
            sr = s - 1 - r;
            sc = s - 1 - c;
         end
         MODE_CW: begin
            sr = s - 1 - c;
            sc = r;
         end
         default: begin
            sr = r;
            sc = c;
         end
      endcase
      return ch * plane + sr * s + sc;
   endfunction

   always @(posedge clock) begin : follow_beats
      int unsigned       s;
      int unsigned       total;
      expected_word_type want;
      if (reset) begin
         expected_words.delete();
         load_pos       = 0;
         drain_pos      = 0;
         mode_q         = MODE_NONE;
         side_q         = side_type'(MAX_SIDE);
         count_q        = count_type'(1);
         mismatch_count = 0;
         words_pending  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ROTATION_MODE: begin
                  mode_q    = mode_type'(csr_wdata[MODE_BITS-1:0]);
                  load_pos  = 0;
                  drain_pos = 0;
               end
               REG_SIDE_LENGTH: begin
                  side_q    = csr_wdata[SIDE_BITS-1:0];
                  load_pos  = 0;
                  drain_pos = 0;
               end
               REG_CHANNEL_COUNT: begin
                  count_q   = csr_wdata[COUNT_BITS-1:0];
                  load_pos  = 0;
                  drain_pos = 0;
               end
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            s     = side_used();
            total = s * s * channels_used();
            if (req_mon.op == OP_LOAD) begin
               if (load_pos >= total) load_pos = 0;
               shadow_store[load_pos] = req_mon.pixel_in;
               load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
            end else begin
               if (drain_pos >= total) drain_pos = 0;
               want.pixel = shadow_store[rotated_source_addr(drain_pos, s)];
               want.last  = (drain_pos + 1 >= total);
               drain_pos  = want.last ? 0 : drain_pos + 1;
               expected_words.push_back(want);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected beat: pixel_out %h frame_last %b",
                      rsp_mon.pixel_out, rsp_mon.frame_last);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.pixel_out !== want.pixel) begin
                  $error("pixel_out: expected %h, actual %h", want.pixel, rsp_mon.pixel_out);
                  mismatch_count++;
               end
               if (rsp_mon.frame_last !== want.last) begin
                  $error("frame_last: expected %b, actual %b", want.last, rsp_mon.frame_last);
                  mismatch_count++;
               end
            end
         end
         words_pending = expected_words.size();
      end
   end

endmodule

FILE: bench/tb_square_image_rotator_top.sv
// Testbench top of the square image rotator: clock, reset, load and drain stimulus, verdict.
module tb_square_image_rotator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sir_pkg::*;

   localparam int unsigned RANDOM_ITEMS      = 1750;
   localparam int unsigned CYCLE_LIMIT       = 1_000_000;
   localparam int unsigned SETTLE_CYCLES     = 6;
   localparam int unsigned IDLE_PERCENT      = 84;
   localparam int unsigned BOTH_IDLE_PERCENT = 23;
   localparam csr_index_type REG_UNMAPPED = 2'd3;
   localparam word_type EDGE_WORDS [9] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hA5A5_A5A5,
      32'h5A5A_5A5A, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h1234_5678
   };

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;
   int            mismatch_count;
   int            words_pending;
   bit            sender_idles    = 1'b0;
   bit            receiver_stalls = 1'b0;
   int unsigned   idle_level      = IDLE_PERCENT;
   int unsigned   cycle_count     = 0;
   int unsigned   frame_words     = MAX_SIDE * MAX_SIDE;
   int unsigned   stored_extent   = 0;
   int unsigned   phase_loads     = 0;
   int unsigned   beats_sent      = 0;

   sir_req_if req_ch ();
   sir_rsp_if rsp_ch ();

   square_image_rotator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tb_rotation_checker rotation_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= !receiver_stalls || ($urandom_range(99) >= idle_level);

   function automatic int unsigned frame_size(csr_data_type side_w, csr_data_type count_w);
      int unsigned s;
      int unsigned c;
      s = (side_w == 0) ? 1 : (side_w > MAX_SIDE) ? MAX_SIDE : side_w;
      c = count_w[COUNT_BITS-1:0];
      c = (c == 0) ? 1 : (c > MAX_CHANNELS) ? MAX_CHANNELS : c;
      return s * s * c;
   endfunction

   task automatic send_beat(input logic op, input word_type pixel);
      if (sender_idles) begin
         while ($urandom_range(99) < idle_level) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.pixel_in <= pixel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      if (op == OP_LOAD) begin
         phase_loads++;
         if (phase_loads <= frame_words && phase_loads > stored_extent)
            stored_extent = phase_loads;
      end
   endtask

   task automatic load_words(int unsigned n);
      repeat (n) send_beat(OP_LOAD, $urandom);
   endtask

   task automatic drain_words(int unsigned n);
      repeat (n) send_beat(OP_DRAIN, $urandom);
   endtask

   // hold valid low until every drained beat is back, then let the pipe empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(csr_index_type idx, csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(csr_data_type mode_w, csr_data_type side_w,
                            csr_data_type count_w, bit spare_write);
      csr_beat(REG_ROTATION_MODE, mode_w);
      csr_beat(REG_SIDE_LENGTH, side_w);
      csr_beat(REG_CHANNEL_COUNT, count_w);
      if (spare_write) csr_beat(REG_UNMAPPED, csr_data_type'($urandom_range(127)));
      csr_we      <= 1'b0;
      frame_words = frame_size(side_w, count_w);
      phase_loads = 0;
   endtask

   task automatic poke_unmapped(csr_data_type data);
      csr_beat(REG_UNMAPPED, data);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned  phase;
      int unsigned  pick;
      int unsigned  hi;
      csr_data_type mode_w;
      csr_data_type side_w;
      csr_data_type count_w;
      bit           mixed;

      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= REG_ROTATION_MODE;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_LOAD;
      req_ch.pixel_in <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      settle();

      // odd side, clockwise, edge words
      configure(csr_data_type'(MODE_CW), 7'd3, 7'd1, 1'b0);
      foreach (EDGE_WORDS[i]) send_beat(OP_LOAD, EDGE_WORDS[i]);
      send_beat(OP_DRAIN, 32'hFFFF_FFFF);
      drain_words(8);
      settle();
      // side and channel count of zero, plus a write to an unmapped index
      configure(csr_data_type'(MODE_180), 7'd0, 7'd0, 1'b1);
      drain_words(2);
      settle();
      // channel count above the limit; unmapped write must keep the positions
      configure(csr_data_type'(MODE_CCW), 7'd1, 7'd7, 1'b0);
      drain_words(2);
      settle();
      poke_unmapped(7'h7F);
      drain_words(2);
      settle();
      configure(csr_data_type'(MODE_NONE), 7'd2, 7'd1, 1'b0);
      drain_words(1);
      settle();

      // load the head of the first plane at the largest side, then drain it clamped
      configure(csr_data_type'(MODE_NONE), 7'd64, 7'd1, 1'b0);
      load_words(MAX_SIDE + 3);
      settle();
      configure(csr_data_type'(MODE_NONE), csr_data_type'($urandom_range(65, 127)),
                7'd0, 1'b0);
      drain_words(MAX_SIDE + 3);

      phase = 0;
      while (beats_sent < RANDOM_ITEMS) begin
         settle();
         sender_idles    = (phase % 4 == 1) || (phase % 4 == 3);
         receiver_stalls = (phase % 4 == 2) || (phase % 4 == 3);
         idle_level      = (phase % 4 == 3) ? BOTH_IDLE_PERCENT : IDLE_PERCENT;
         pick   = $urandom_range(19);
         hi     = $urandom_range(15);
         mode_w = csr_data_type'($urandom_range(127));
         if (pick == 0 && stored_extent >= MAX_SIDE * MAX_SIDE) begin
            side_w  = csr_data_type'($urandom_range(MAX_SIDE, 127));
            count_w = {4'(hi), 3'($urandom_range(1))};
         end else if (pick < 4) begin
            side_w  = csr_data_type'($urandom_range(7, 16));
            count_w = {4'(hi), 3'd1};
         end else begin
            side_w  = csr_data_type'($urandom_range(6));
            count_w = {4'(hi), 3'($urandom_range(7))};
         end
         configure(mode_w, side_w, count_w, $urandom_range(3) == 0);
         mixed = (frame_words > 1024) || ($urandom_range(9) < 3);
         if (mixed) begin
            repeat ($urandom_range(10, 60)) begin
               if (stored_extent >= frame_words && $urandom_range(1))
                  send_beat(OP_DRAIN, $urandom);
               else
                  send_beat(OP_LOAD, $urandom);
            end
         end else begin
            repeat ($urandom_range(1, 2)) begin
               load_words(frame_words);
               drain_words(frame_words);
            end
         end
         phase++;
      end

      settle();
      if (mismatch_count == 0 && words_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/sir_pkg.sv
rtl/core/sir_channels_if.sv
rtl/core/square_image_rotator_top.sv
bench/tb_rotation_checker.sv
bench/tb_square_image_rotator_top.sv
